>>> rtl/vfv_pkg.sv
// Shared types and constants for the voxel face visibility mask block.
// Used by vfv_addr and the top level; depends on nothing.
package vfv_pkg;

  localparam int unsigned LevelW = 3;
  localparam int unsigned CoordW = 5;
  localparam int unsigned MaskW  = 6;
  localparam int unsigned CfgW   = 3;
  localparam int unsigned StepW  = 3;

  // Item commands
  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // Configuration register indexes
  localparam logic RegEdgeLog2 = 1'b0;
  localparam logic RegBorder   = 1'b1;

  // Read steps: centre voxel, then the six neighbours in face order
  localparam logic [StepW-1:0] StepCentre = 3'd0;
  localparam logic [StepW-1:0] StepLast   = 3'd6;

  // Face bit positions in the mask
  localparam int unsigned FaceLeft   = 0;
  localparam int unsigned FaceRight  = 1;
  localparam int unsigned FaceBottom = 2;
  localparam int unsigned FaceTop    = 3;
  localparam int unsigned FaceFront  = 4;
  localparam int unsigned FaceBack   = 5;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StClear = 6'b000010,
    StWrite = 6'b000100,
    StRead  = 6'b001000,
    StWait  = 6'b010000,
    StDone  = 6'b100000
  } state_e;

endpackage

>>> rtl/vfv_ram.sv
// Single-port occupancy memory, one bit per voxel, registered read data.
// Depends on nothing.
module vfv_ram #(
  parameter int unsigned Depth = 37449,
  parameter int unsigned AW    = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic          wdata_i,
  output logic          rdata_o
);

  logic mem [Depth];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/vfv_addr.sv
// Range check and linear address of a voxel in the level pyramid.
// Depends on vfv_pkg.
module vfv_addr #(
  parameter int unsigned LgMax = 5,
  parameter int unsigned AW    = 16
) (
  input  logic [vfv_pkg::CfgW-1:0]   edge_log2_i,
  input  logic [vfv_pkg::LevelW-1:0] level_i,
  input  logic [vfv_pkg::CoordW-1:0] pos_x_i,
  input  logic [vfv_pkg::CoordW-1:0] pos_y_i,
  input  logic [vfv_pkg::CoordW-1:0] pos_z_i,
  output logic [AW-1:0]              addr_o,
  output logic [vfv_pkg::LevelW-1:0] level_log2_o,
  output logic                       bad_o
);

  logic [vfv_pkg::CfgW-1:0]   lg;
  logic [vfv_pkg::LevelW-1:0] lgl;
  logic [31:0]                off;
  logic [31:0]                lin;

  always_comb begin
    lg  = (edge_log2_i < vfv_pkg::CfgW'(LgMax)) ? edge_log2_i : vfv_pkg::CfgW'(LgMax);
    lgl = lg - level_i;
    // a coordinate is out of range when any bit at or above the level's log2 is set
    bad_o = (level_i > lg)
         || ((pos_x_i >> lgl) != '0)
         || ((pos_y_i >> lgl) != '0)
         || ((pos_z_i >> lgl) != '0);
    // levels are whole powers of eight in size, so the offset is a sparse bit pattern
    off = '0;
    for (int i = 0; i < 7; i++) begin
      if ((3'(i) < level_i) && (3'(i) <= lg)) begin
        off = off | (32'd1 << (3 * (int'(lg) - i)));
      end
    end
    lin = 32'(pos_x_i) | (32'(pos_y_i) << lgl) | (32'(pos_z_i) << {lgl, 1'b0});
    addr_o       = AW'(off | lin);
    level_log2_o = lgl;
  end

endmodule

>>> rtl/voxel_face_visibility_mask.sv
// Top level of the voxel face visibility mask block: sequencer, registers
// and output stage. Depends on vfv_pkg, vfv_addr and vfv_ram.
//
// After reset the block sweeps the occupancy memory to empty, one voxel per
// cycle, and takes no item meanwhile; configuration writes are taken at any
// time. A load gives no result. An in-range query takes the item, makes
// seven reads of the single-port memory (the voxel and its six neighbours,
// through one shared address adder), captures the last read and then forms
// the result. An out-of-range query goes from taking the item straight to
// forming the result. The result waits in an output register until taken.
module voxel_face_visibility_mask #(
  parameter int unsigned MAX_EDGE = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [vfv_pkg::CfgW-1:0]          cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic [vfv_pkg::LevelW-1:0]        level_i,
  input  logic [vfv_pkg::CoordW-1:0]        pos_x_i,
  input  logic [vfv_pkg::CoordW-1:0]        pos_y_i,
  input  logic [vfv_pkg::CoordW-1:0]        pos_z_i,
  input  logic                              occupied_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [vfv_pkg::MaskW-1:0]         face_mask_o,
  output logic                              out_of_range_o
);

  localparam int unsigned Depth = (MAX_EDGE * MAX_EDGE * MAX_EDGE * 8) / 7 + 1;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned LgMax = $clog2(MAX_EDGE + 1) - 1;

  vfv_pkg::state_e state_q, state_d;

  logic [vfv_pkg::CfgW-1:0]   edge_q;
  logic                       border_q;
  logic                       cmd_q;
  logic                       occ_q;
  logic                       bad_q;
  logic [vfv_pkg::LevelW-1:0] lgl_q;
  logic [AW-1:0]              base_q;
  logic [vfv_pkg::CoordW-1:0] x_q, y_q, z_q;
  logic [vfv_pkg::StepW-1:0]  step_q;
  logic                       rd_pend_q;
  logic [vfv_pkg::StepW-1:0]  rd_idx_q;
  logic [6:0]                 bits_q;
  logic [AW-1:0]              clr_q;
  logic                       out_valid_q;
  logic [vfv_pkg::MaskW-1:0]  mask_q;
  logic                       oor_q;

  logic [AW-1:0]              addr;
  logic [vfv_pkg::LevelW-1:0] lgl;
  logic                       bad;
  logic                       accept;
  logic                       out_free;
  logic [AW-1:0]              mag;
  logic [AW-1:0]              naddr;
  logic                       ram_en, ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]              ram_addr;
  logic [vfv_pkg::MaskW-1:0]  mask;
  logic                       lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic [6:0]                 edge_len;

  vfv_addr #(
    .LgMax (LgMax),
    .AW    (AW)
  ) u_addr (
    .edge_log2_i  (edge_q),
    .level_i      (level_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .addr_o       (addr),
    .level_log2_o (lgl),
    .bad_o        (bad)
  );

  vfv_ram #(
    .Depth (Depth),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == vfv_pkg::StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Shared neighbour adder: odd steps step backwards, even steps forwards
  always_comb begin
    unique case (step_q)
      3'd1, 3'd2: mag = AW'(1);
      3'd3, 3'd4: mag = AW'(32'd1 << lgl_q);
      3'd5, 3'd6: mag = AW'(32'd1 << {lgl_q, 1'b0});
      default:    mag = '0;
    endcase
    naddr = step_q[0] ? (base_q - mag) : (base_q + mag);
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = base_q;
    ram_wdata = occ_q;
    unique case (state_q)
      vfv_pkg::StClear: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = 1'b0;
      end
      vfv_pkg::StWrite: begin
        ram_en = !bad_q;
        ram_we = 1'b1;
      end
      vfv_pkg::StRead: begin
        ram_en   = 1'b1;
        ram_addr = naddr;
      end
      default: ;
    endcase
  end

  // Face mask from the captured centre and neighbour bits
  always_comb begin
    edge_len = 7'd1 << lgl_q;
    lo_x = (x_q == '0);
    lo_y = (y_q == '0);
    lo_z = (z_q == '0);
    hi_x = ((7'(x_q) + 7'd1) == edge_len);
    hi_y = ((7'(y_q) + 7'd1) == edge_len);
    hi_z = ((7'(z_q) + 7'd1) == edge_len);
    mask = '0;
    if (!bad_q && bits_q[0]) begin
      mask[vfv_pkg::FaceLeft]   = lo_x ? border_q : !bits_q[1];
      mask[vfv_pkg::FaceRight]  = hi_x ? border_q : !bits_q[2];
      mask[vfv_pkg::FaceBottom] = lo_y ? border_q : !bits_q[3];
      mask[vfv_pkg::FaceTop]    = hi_y ? border_q : !bits_q[4];
      mask[vfv_pkg::FaceFront]  = lo_z ? border_q : !bits_q[5];
      mask[vfv_pkg::FaceBack]   = hi_z ? border_q : !bits_q[6];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vfv_pkg::StIdle: begin
        if (accept) begin
          if (cmd_i == vfv_pkg::CmdLoad) begin
            state_d = vfv_pkg::StWrite;
          end else if (bad) begin
            state_d = vfv_pkg::StDone;
          end else begin
            state_d = vfv_pkg::StRead;
          end
        end
      end
      vfv_pkg::StClear: begin
        if (clr_q == AW'(Depth - 1)) begin
          state_d = vfv_pkg::StIdle;
        end
      end
      vfv_pkg::StWrite: state_d = vfv_pkg::StIdle;
      vfv_pkg::StRead: begin
        if (step_q == vfv_pkg::StepLast) begin
          state_d = vfv_pkg::StWait;
        end
      end
      vfv_pkg::StWait: state_d = vfv_pkg::StDone;
      vfv_pkg::StDone: begin
        if (out_free) begin
          state_d = vfv_pkg::StIdle;
        end
      end
      default: state_d = vfv_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vfv_pkg::StClear;
      edge_q      <= 3'd5;
      border_q    <= 1'b1;
      clr_q       <= '0;
      step_q      <= vfv_pkg::StepCentre;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          vfv_pkg::RegEdgeLog2: edge_q   <= cfg_wdata_i;
          vfv_pkg::RegBorder:   border_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (state_q == vfv_pkg::StClear) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == vfv_pkg::StRead) begin
        step_q <= step_q + 3'd1;
      end else begin
        step_q <= vfv_pkg::StepCentre;
      end
      rd_pend_q <= (state_q == vfv_pkg::StRead);
      if ((state_q == vfv_pkg::StDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: item fields, read capture, result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      occ_q  <= occupied_i;
      bad_q  <= bad;
      lgl_q  <= lgl;
      base_q <= addr;
      x_q    <= pos_x_i;
      y_q    <= pos_y_i;
      z_q    <= pos_z_i;
    end
    rd_idx_q <= step_q;
    if (rd_pend_q) begin
      bits_q[rd_idx_q] <= ram_rdata;
    end
    if ((state_q == vfv_pkg::StDone) && out_free) begin
      mask_q <= mask;
      oor_q  <= bad_q && (cmd_q == vfv_pkg::CmdQuery);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign face_mask_o    = mask_q;
  assign out_of_range_o = oor_q;

endmodule

>>> test/tb.sv
// Self-checking testbench for voxel_face_visibility_mask: random and directed
// load/query items, a bit-level occupancy predictor and an in-order result check.
// Depends on vfv_pkg and the RTL of the block.
module tb;

  localparam int unsigned MaxEdge       = 32;
  localparam int unsigned MaxLog2       = $clog2(MaxEdge);
  localparam int unsigned StoreDepth    = MaxEdge * MaxEdge * MaxEdge * 8 / 7 + 1;
  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned DrainCycles   = 24;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned TimeoutCycles = 600_000;
  localparam int unsigned NumPhases     = 8;

  typedef struct {
    logic                       cmd;
    logic [vfv_pkg::LevelW-1:0] level;
    logic [vfv_pkg::CoordW-1:0] pos_x;
    logic [vfv_pkg::CoordW-1:0] pos_y;
    logic [vfv_pkg::CoordW-1:0] pos_z;
    logic                       occupied;
  } voxel_item_t;

  typedef struct {
    logic [vfv_pkg::MaskW-1:0] face_mask;
    logic                      out_of_range;
  } face_result_t;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       cfg_we_i       = 1'b0;
  logic                       cfg_index_i    = vfv_pkg::RegEdgeLog2;
  logic [vfv_pkg::CfgW-1:0]   cfg_wdata_i    = '0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_ready_o;
  logic                       cmd_i          = vfv_pkg::CmdLoad;
  logic [vfv_pkg::LevelW-1:0] level_i        = '0;
  logic [vfv_pkg::CoordW-1:0] pos_x_i        = '0;
  logic [vfv_pkg::CoordW-1:0] pos_y_i        = '0;
  logic [vfv_pkg::CoordW-1:0] pos_z_i        = '0;
  logic                       occupied_i     = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i    = 1'b0;
  logic [vfv_pkg::MaskW-1:0]  face_mask_o;
  logic                       out_of_range_o;

  voxel_face_visibility_mask #(
    .MAX_EDGE(MaxEdge)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .level_i       (level_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .occupied_i    (occupied_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .face_mask_o   (face_mask_o),
    .out_of_range_o(out_of_range_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Occupancy predictor state and its copy of the registers
  bit                       occupancy_model [StoreDepth];
  logic [vfv_pkg::CfgW-1:0] model_edge_log2 = 3'd5;
  logic                     model_border    = 1'b1;

  voxel_item_t  voxel_items_todo[$];
  face_result_t face_results_due[$];
  voxel_item_t  item_on_bus;

  int unsigned tx_max_gap    = 0;
  int unsigned rx_max_stall  = 0;
  int unsigned gap_left      = 0;
  int unsigned stall_left    = 0;
  int unsigned long_hold_left = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  logic        next_valid;

  int unsigned loads_taken    = 0;
  int unsigned queries_taken  = 0;
  int unsigned results_seen   = 0;
  int unsigned settings_run   = 0;
  int unsigned fail_count     = 0;

  function automatic bit model_bit(input int unsigned addr);
    return (addr < StoreDepth) ? occupancy_model[addr] : 1'b0;
  endfunction

  // Apply one accepted item to the occupancy model; queue the mask a query yields
  task automatic apply_voxel_item(input voxel_item_t it);
    int unsigned  lg;
    int unsigned  e;
    int unsigned  addr;
    int unsigned  x;
    int unsigned  y;
    int unsigned  z;
    logic         bad;
    face_result_t res;
    lg   = (model_edge_log2 > MaxLog2) ? MaxLog2 : model_edge_log2;
    x    = it.pos_x;
    y    = it.pos_y;
    z    = it.pos_z;
    bad  = it.level > lg;
    e    = bad ? 0 : ((1 << lg) >> it.level);
    bad  = bad || x >= e || y >= e || z >= e;
    addr = 0;
    if (!bad) begin
      for (int unsigned l = 0; l < it.level; l++) begin
        addr += ((1 << lg) >> l) ** 3;
      end
      addr += x + e * (y + e * z);
    end
    if (it.cmd == vfv_pkg::CmdLoad) begin
      loads_taken++;
      if (!bad && addr < StoreDepth) occupancy_model[addr] = it.occupied;
    end else begin
      queries_taken++;
      res.face_mask    = '0;
      res.out_of_range = bad;
      if (!bad && model_bit(addr)) begin
        res.face_mask[vfv_pkg::FaceLeft]   = (x == 0)     ? model_border
                                                          : !model_bit(addr - 1);
        res.face_mask[vfv_pkg::FaceRight]  = (x == e - 1) ? model_border
                                                          : !model_bit(addr + 1);
        res.face_mask[vfv_pkg::FaceBottom] = (y == 0)     ? model_border
                                                          : !model_bit(addr - e);
        res.face_mask[vfv_pkg::FaceTop]    = (y == e - 1) ? model_border
                                                          : !model_bit(addr + e);
        res.face_mask[vfv_pkg::FaceFront]  = (z == 0)     ? model_border
                                                          : !model_bit(addr - e * e);
        res.face_mask[vfv_pkg::FaceBack]   = (z == e - 1) ? model_border
                                                          : !model_bit(addr + e * e);
      end
      face_results_due.push_back(res);
    end
  endtask

  // Sender: one item at a time from the pending queue, random gap after each
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   = 0;
    end else begin
      next_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        apply_voxel_item(item_on_bus);
        next_valid = 1'b0;
        gap_left   = $urandom_range(0, tx_max_gap);
      end
      if (!next_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (voxel_items_todo.size() != 0) begin
          item_on_bus = voxel_items_todo.pop_front();
          cmd_i      <= item_on_bus.cmd;
          level_i    <= item_on_bus.level;
          pos_x_i    <= item_on_bus.pos_x;
          pos_y_i    <= item_on_bus.pos_y;
          pos_z_i    <= item_on_bus.pos_z;
          occupied_i <= item_on_bus.occupied;
          next_valid = 1'b1;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // Receiver: check each result against the oldest expectation, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (face_results_due.size() == 0) begin
          $error("result with no expectation: face_mask %0h out_of_range %0b",
                 face_mask_o, out_of_range_o);
          fail_count++;
        end else begin
          if (face_mask_o !== face_results_due[0].face_mask) begin
            $error("face_mask: expected %0h, actual %0h",
                   face_results_due[0].face_mask, face_mask_o);
            fail_count++;
          end
          if (out_of_range_o !== face_results_due[0].out_of_range) begin
            $error("out_of_range: expected %0b, actual %0b",
                   face_results_due[0].out_of_range, out_of_range_o);
            fail_count++;
          end
          void'(face_results_due.pop_front());
        end
        stall_left = $urandom_range(0, rx_max_stall);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      if (hold_served != hold_requests) begin
        hold_served    = hold_requests;
        long_hold_left = HoldCycles;
      end else if (long_hold_left != 0) begin
        long_hold_left--;
      end
      out_ready_i <= (stall_left == 0) && (long_hold_left == 0);
    end
  end

  task automatic push_item(input logic cmd, input int unsigned lvl, input int unsigned x,
                           input int unsigned y, input int unsigned z, input logic occ);
    voxel_item_t it;
    it.cmd      = cmd;
    it.level    = lvl[vfv_pkg::LevelW-1:0];
    it.pos_x    = x[vfv_pkg::CoordW-1:0];
    it.pos_y    = y[vfv_pkg::CoordW-1:0];
    it.pos_z    = z[vfv_pkg::CoordW-1:0];
    it.occupied = occ;
    voxel_items_todo.push_back(it);
  endtask

  task automatic write_register(input logic idx, input logic [vfv_pkg::CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == vfv_pkg::RegEdgeLog2) model_edge_log2 = value;
    else model_border = value[0];
  endtask

  task automatic wait_until_idle();
    while (voxel_items_todo.size() != 0 || in_valid_i || face_results_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Mostly loads and queries packed into a small cluster, so that neighbours
  // are often occupied; the rest is unconstrained noise
  task automatic queue_random_items(input int unsigned count);
    int unsigned lg;
    int unsigned e;
    int unsigned span;
    int unsigned lvl;
    int unsigned org[3];
    int unsigned roll;
    lg   = (model_edge_log2 > MaxLog2) ? MaxLog2 : model_edge_log2;
    lvl  = 0;
    span = 1;
    org  = '{0, 0, 0};
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        lvl  = $urandom_range(0, lg);
        e    = (1 << lg) >> lvl;
        span = (e < 3) ? e : 3;
        for (int a = 0; a < 3; a++) begin
          roll   = $urandom_range(0, 3);
          org[a] = (roll == 0) ? 0 : (roll == 1) ? e - span : $urandom_range(0, e - span);
        end
      end
      if ($urandom_range(0, 99) < 80) begin
        push_item(($urandom_range(0, 99) < 45) ? vfv_pkg::CmdQuery : vfv_pkg::CmdLoad,
                  lvl,
                  org[0] + $urandom_range(0, span - 1),
                  org[1] + $urandom_range(0, span - 1),
                  org[2] + $urandom_range(0, span - 1),
                  $urandom_range(0, 3) != 0);
      end else begin
        push_item(($urandom_range(0, 1) != 0) ? vfv_pkg::CmdQuery : vfv_pkg::CmdLoad,
                  $urandom_range(0, 7), $urandom_range(0, 31),
                  $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 1) != 0);
      end
    end
  endtask

  // Corners, borders, the one-voxel level, out-of-range levels and coordinates
  task automatic queue_directed_items();
    push_item(vfv_pkg::CmdQuery, 0, 0, 0, 0, 1'b0);
    push_item(vfv_pkg::CmdLoad,  0, 0, 0, 0, 1'b1);
    push_item(vfv_pkg::CmdQuery, 0, 0, 0, 0, 1'b0);
    push_item(vfv_pkg::CmdLoad,  0, 1, 0, 0, 1'b1);
    push_item(vfv_pkg::CmdLoad,  0, 0, 1, 0, 1'b1);
    push_item(vfv_pkg::CmdLoad,  0, 0, 0, 1, 1'b1);
    push_item(vfv_pkg::CmdQuery, 0, 0, 0, 0, 1'b0);
    push_item(vfv_pkg::CmdQuery, 0, 1, 0, 0, 1'b1);
    push_item(vfv_pkg::CmdLoad,  0, 31, 31, 31, 1'b1);
    push_item(vfv_pkg::CmdQuery, 0, 31, 31, 31, 1'b0);
    push_item(vfv_pkg::CmdLoad,  5, 0, 0, 0, 1'b1);
    push_item(vfv_pkg::CmdQuery, 5, 0, 0, 0, 1'b0);
    push_item(vfv_pkg::CmdQuery, 6, 0, 0, 0, 1'b0);
    push_item(vfv_pkg::CmdQuery, 7, 31, 31, 31, 1'b1);
    push_item(vfv_pkg::CmdLoad,  1, 16, 0, 0, 1'b1);
    push_item(vfv_pkg::CmdQuery, 1, 16, 0, 0, 1'b0);
    push_item(vfv_pkg::CmdQuery, 1, 15, 15, 15, 1'b0);
    push_item(vfv_pkg::CmdLoad,  0, 0, 0, 0, 1'b0);
    push_item(vfv_pkg::CmdQuery, 0, 0, 0, 0, 1'b0);
    push_item(vfv_pkg::CmdLoad,  6, 0, 0, 0, 1'b1);
  endtask

  int unsigned phase_edge  [NumPhases] = '{5, 2, 0, 7, 3, 6, 1, 4};
  int unsigned phase_border[NumPhases] = '{1, 0, 1, 0, 1, 1, 0, 0};
  int unsigned phase_items [NumPhases] = '{300, 200, 100, 250, 200, 150, 150, 100};
  int unsigned phase_gap   [NumPhases] = '{6, 0, 6, 3, 6, 0, 6, 6};
  int unsigned phase_stall [NumPhases] = '{6, 0, 6, 6, 0, 3, 6, 6};

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Store is not cleared between settings: later phases read old contents
    // under the new layout
    for (int p = 0; p < NumPhases; p++) begin
      wait_until_idle();
      write_register(vfv_pkg::RegEdgeLog2, phase_edge[p][vfv_pkg::CfgW-1:0]);
      write_register(vfv_pkg::RegBorder, phase_border[p][vfv_pkg::CfgW-1:0]);
      settings_run++;
      tx_max_gap   = phase_gap[p];
      rx_max_stall = phase_stall[p];
      @(negedge clk_i);
      if (p == 0) queue_directed_items();
      // Back-pressure the output while the sender keeps offering items
      if (p == 1) hold_requests++;
      queue_random_items(phase_items[p]);
    end
    wait_until_idle();
    $display("Covered %0d loads and %0d queries over %0d register settings,",
             loads_taken, queries_taken, settings_run);
    $display("%0d results checked, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("Timed out with %0d results outstanding", face_results_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
rtl/vfv_pkg.sv
rtl/vfv_ram.sv
rtl/vfv_addr.sv
rtl/voxel_face_visibility_mask.sv
test/tb.sv
